// File: sv/lbdg_pkg.sv
// ----------------------------------------------------------------------------
// Load-based DVFS governor package
// Shared constants and types for the governor core and its divider.
// ----------------------------------------------------------------------------
package lbdg_pkg;

  localparam int DVD_W = 39;
  localparam int DVS_W = 32;
  localparam int FREQ_W = 22;
  localparam int PEAK_W = 29;
  localparam int MULT_W = 17;
  localparam int PCT_W = 7;

  // Reciprocal of 11 scaled by 2^35; exact for dividends below 2^33.
  localparam logic [31:0] RECIP_11 = 32'd3123612579;
  // Reciprocal of 25 scaled by 2^30; a division by 100 drops two bits first.
  localparam logic [25:0] RECIP_25 = 26'd42949673;
  localparam logic [MULT_W-1:0] MULT_MAX = 17'd100000;

  localparam logic [2:0] CFG_UP_TH = 3'd0;
  localparam logic [2:0] CFG_DOWN_DIFF = 3'd1;
  localparam logic [2:0] CFG_FREQ_STEP = 3'd2;
  localparam logic [2:0] CFG_LOW_UP_TH = 3'd3;
  localparam logic [2:0] CFG_RESP_FREQ = 3'd4;
  localparam logic [2:0] CFG_DOWN_DELAY = 3'd5;
  localparam logic [2:0] CFG_MAX_FREQ = 3'd6;
  localparam logic [2:0] CFG_MIN_FREQ = 3'd7;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dvd;
    logic [DVS_W-1:0] dvs;
  } div_req_t;

endpackage

// File: sv/lbdg_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lbdg_ram #(
  parameter int W = 8,
  parameter int D = 4
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0]  waddr,
  input  logic [W-1:0]                          wdata,
  input  logic                                  re,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0]  raddr,
  output logic [W-1:0]                          rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/lbdg_div.sv
// ----------------------------------------------------------------------------
// Shared restoring divider
// Unsigned division, one quotient bit per cycle, done pulses with the result.
// ----------------------------------------------------------------------------
module lbdg_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lbdg_pkg::div_req_t       req,
  output logic                     done,
  output logic [lbdg_pkg::DVD_W-1:0] quo
);
  import lbdg_pkg::*;

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] sh_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CW-1:0]    cnt_r;
  logic             done_r;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   trial;

  assign shifted = {rem_r, sh_r[DVD_W-1]};
  assign trial = shifted - {1'b0, dvs_r};
  assign done = done_r;
  assign quo = sh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        sh_r <= req.dvd;
        dvs_r <= req.dvs;
        rem_r <= '0;
        cnt_r <= CW'(DVD_W);
      end else if (cnt_r != '0) begin
        if (!trial[DVS_W]) begin
          rem_r <= trial[DVS_W-1:0];
          sh_r <= {sh_r[DVD_W-2:0], 1'b1};
        end else begin
          rem_r <= shifted[DVS_W-1:0];
          sh_r <= {sh_r[DVD_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        done_r <= (cnt_r == CW'(1));
      end
    end
  end

endmodule

// File: sv/load_based_dvfs_governor_core.sv
// ----------------------------------------------------------------------------
// Load-based DVFS governor core
// Per-core load sampling with a peak tracker and a frequency decision.
// ----------------------------------------------------------------------------
// The block takes one sample at a time and holds in_tready low until the
// sample is finished. Per-core history (previous wall and idle counters and
// the smoothed wall delta) lives in one RAM with a registered read, and the
// smoothing division by 11 and the step division by 100 use reciprocal
// multiplications. The divisions by the wall delta, by the threshold margin
// and by the new frequency share one divider that produces one quotient bit
// per cycle, and that divider sets the rate: a counted sample waits for one
// division, while a skipped one does not use it. The sample that ends the
// period uses the divider once more for a decrease and twice when the floor
// bump check needs a second division, and not at all for a kept frequency or
// a raise; it also waits for any earlier result that has not been taken yet.
// A result is produced only for a sample marked with in_tlast.
// ----------------------------------------------------------------------------
module load_based_dvfs_governor_core #(
  parameter int CORES = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // core_index[1:0], wall_time_us[33:2], idle_time_us[65:34],
  // avg_freq_khz[87:66], cur_freq_khz[109:88]
  input  logic [111:0]  in_tdata,
  input  logic          in_tlast,
  output logic          out_tvalid,
  input  logic          out_tready,
  // change_request[0], target_freq_khz[22:1], rate_multiplier[39:23],
  // peak_load_freq[68:40]
  output logic [71:0]   out_tdata,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [21:0]   cfg_data
);
  import lbdg_pkg::*;

  localparam int AW = (CORES > 1) ? $clog2(CORES) : 1;
  localparam logic [4:0] CORES_V = 5'(CORES);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_CHK, S_SMD, S_SMW, S_LDD, S_LF, S_DEC, S_CMP, S_INC, S_NXT, S_BMP,
    S_OUT
  } st_t;

  st_t st_r;

  logic [PCT_W-1:0]  ut_r, dd_r, fstep_r, lfut_r;
  logic [FREQ_W-1:0] resp_r, mx_r, mn_r;
  logic [MULT_W-1:0] ddf_r;

  logic [AW-1:0]     addr_r;
  logic [31:0]       wall_in_r, idle_in_r;
  logic [FREQ_W-1:0] freq_r, cur_r;
  logic              last_r;
  logic [31:0]       wall_r, idle_r, sm_r;
  logic              skip_r;
  logic              smge_r;
  logic [32:0]       smx_r;
  logic [64:0]       smp_r;
  logic [52:0]       incp_r;
  logic [PCT_W-1:0]  load_r;
  logic [PEAK_W-1:0] peak_r, upcmp_r, dncmp_r, mxstep_r, next_r;
  logic [MULT_W-1:0] rmult_r;
  logic              chg_r;
  logic [FREQ_W-1:0] tgt_r;
  logic              out_valid_r;
  logic [71:0]       out_data_r;
  logic [CORES-1:0]  vld_r;
  div_req_t          div_req_r;

  logic              div_done;
  logic [DVD_W-1:0]  div_quo;
  logic              ram_we, ram_re;
  logic [95:0]       ram_wdata, ram_rdata, hist;
  logic              in_acc;
  logic              core_ok;
  logic [34:0]       wall5, sm5;
  logic              deep;
  logic [29:0]       smq;
  logic [31:0]       sm_new;
  logic [22:0]       inc;
  logic [PCT_W-1:0]  th, diff;
  logic [FREQ_W-1:0] mn_eff;
  logic [29:0]       t_sum, t_cap;
  logic [PEAK_W-1:0] nx, bmp_next;
  logic [PEAK_W-1:0] lf;
  logic [MULT_W-1:0] ddf_clamp;

  assign in_acc = in_tvalid && in_tready;
  assign in_tready = (st_r == S_IDLE);
  assign core_ok = ({3'b000, in_tdata[1:0]} < CORES_V);
  assign ram_re = in_acc && core_ok;
  assign ram_we = (st_r == S_SMW);
  assign smq = smp_r[64:35];
  assign sm_new = smge_r ? (sm_r + 32'(smq)) : (sm_r - 32'(smq));
  assign ram_wdata = {wall_in_r, idle_in_r, sm_new};
  assign hist = vld_r[addr_r] ? ram_rdata : '0;

  assign wall5 = 35'(wall_r) * 35'd5;
  assign sm5 = 35'(sm_r) * 35'd5;
  assign deep = (35'(sm_r) > wall5) || (sm5 < 35'(wall_r));

  assign inc = incp_r[52:30];
  assign th = (cur_r < resp_r) ? lfut_r : ut_r;
  assign diff = ut_r - dd_r;
  assign mn_eff = (mn_r == '0) ? FREQ_W'(1) : mn_r;
  assign t_sum = 30'(cur_r) + 30'(inc);
  assign t_cap = (t_sum > 30'(mx_r)) ? 30'(mx_r) : t_sum;
  assign nx = (div_quo[PEAK_W-1:0] < PEAK_W'(mn_eff)) ? PEAK_W'(mn_eff)
                                                       : div_quo[PEAK_W-1:0];
  assign bmp_next = (div_quo[PEAK_W-1:0] > PEAK_W'(lfut_r - dd_r)) ? PEAK_W'(resp_r)
                                                                     : next_r;
  assign lf = PEAK_W'(load_r) * PEAK_W'(freq_r);
  assign ddf_clamp = (ddf_r == '0) ? MULT_W'(1) : ((ddf_r > MULT_MAX) ? MULT_MAX : ddf_r);

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  lbdg_ram #(.W(96), .D(CORES)) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (AW'(in_tdata[1:0])),
    .rdata (ram_rdata)
  );

  lbdg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ut_r <= 7'd82;
      dd_r <= 7'd5;
      fstep_r <= 7'd37;
      lfut_r <= 7'd40;
      resp_r <= 22'd400000;
      ddf_r <= 17'd1;
      mx_r <= 22'd1200000;
      mn_r <= 22'd200000;
      vld_r <= '0;
      peak_r <= '0;
      rmult_r <= 17'd1;
      out_valid_r <= 1'b0;
      div_req_r.start <= 1'b0;
    end else begin
      div_req_r.start <= 1'b0;
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_UP_TH: ut_r <= cfg_data[PCT_W-1:0];
          CFG_DOWN_DIFF: dd_r <= cfg_data[PCT_W-1:0];
          CFG_FREQ_STEP: fstep_r <= cfg_data[PCT_W-1:0];
          CFG_LOW_UP_TH: lfut_r <= cfg_data[PCT_W-1:0];
          CFG_RESP_FREQ: resp_r <= cfg_data;
          CFG_DOWN_DELAY: begin
            ddf_r <= cfg_data[MULT_W-1:0];
            rmult_r <= 17'd1;
          end
          CFG_MAX_FREQ: mx_r <= cfg_data;
          CFG_MIN_FREQ: mn_r <= cfg_data;
          default: ;
        endcase
      end
      case (st_r)
        S_IDLE: begin
          if (in_acc) begin
            addr_r <= AW'(in_tdata[1:0]);
            wall_in_r <= in_tdata[33:2];
            idle_in_r <= in_tdata[65:34];
            freq_r <= (in_tdata[87:66] != '0) ? in_tdata[87:66] : in_tdata[109:88];
            cur_r <= in_tdata[109:88];
            last_r <= in_tlast;
            st_r <= core_ok ? S_RD : S_DEC;
          end
        end
        S_RD: begin
          wall_r <= wall_in_r - hist[95:64];
          idle_r <= idle_in_r - hist[63:32];
          sm_r <= hist[31:0];
          st_r <= S_CHK;
        end
        S_CHK: begin
          skip_r <= deep || (wall_r == '0) || (wall_r < idle_r);
          smge_r <= (wall_r >= sm_r);
          smx_r <= (wall_r >= sm_r) ? 33'(wall_r - sm_r) : 33'(sm_r - wall_r) + 33'd10;
          st_r <= S_SMD;
        end
        S_SMD: begin
          smp_r <= 65'(smx_r) * 65'(RECIP_11);
          st_r <= S_SMW;
        end
        S_SMW: begin
          vld_r[addr_r] <= 1'b1;
          if (skip_r) begin
            st_r <= S_DEC;
          end else begin
            div_req_r.start <= 1'b1;
            div_req_r.dvd <= 39'(wall_r - idle_r) * 39'd100;
            div_req_r.dvs <= wall_r;
            st_r <= S_LDD;
          end
        end
        S_LDD: begin
          if (div_done) begin
            load_r <= div_quo[PCT_W-1:0];
            st_r <= S_LF;
          end
        end
        S_LF: begin
          if (lf > peak_r) begin
            peak_r <= lf;
          end
          st_r <= S_DEC;
        end
        S_DEC: begin
          upcmp_r <= PEAK_W'(th) * PEAK_W'(cur_r);
          dncmp_r <= PEAK_W'(diff) * PEAK_W'(cur_r);
          mxstep_r <= PEAK_W'(mx_r) * PEAK_W'(fstep_r);
          st_r <= last_r ? S_CMP : S_IDLE;
        end
        S_CMP: begin
          chg_r <= 1'b0;
          tgt_r <= '0;
          if (peak_r > upcmp_r) begin
            incp_r <= 53'(mxstep_r[PEAK_W-1:2]) * 53'(RECIP_25);
            st_r <= S_INC;
          end else if ((dd_r < ut_r) && (peak_r < dncmp_r)) begin
            rmult_r <= 17'd1;
            div_req_r.start <= 1'b1;
            div_req_r.dvd <= 39'(peak_r);
            div_req_r.dvs <= 32'(diff);
            st_r <= S_NXT;
          end else begin
            st_r <= S_OUT;
          end
        end
        S_INC: begin
          if ((cur_r < mx_r) && (t_cap == 30'(mx_r))) begin
            rmult_r <= ddf_clamp;
          end
          chg_r <= 1'b1;
          tgt_r <= t_cap[FREQ_W-1:0];
          st_r <= S_OUT;
        end
        S_NXT: begin
          if (div_done) begin
            next_r <= nx;
            if ((nx < PEAK_W'(resp_r)) && (dd_r <= lfut_r)) begin
              div_req_r.start <= 1'b1;
              div_req_r.dvd <= 39'(peak_r);
              div_req_r.dvs <= 32'(nx);
              st_r <= S_BMP;
            end else begin
              chg_r <= (nx != PEAK_W'(cur_r));
              tgt_r <= (nx != PEAK_W'(cur_r)) ? nx[FREQ_W-1:0] : '0;
              st_r <= S_OUT;
            end
          end
        end
        S_BMP: begin
          if (div_done) begin
            chg_r <= (bmp_next != PEAK_W'(cur_r));
            tgt_r <= (bmp_next != PEAK_W'(cur_r)) ? bmp_next[FREQ_W-1:0] : '0;
            st_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r <= {3'b000, peak_r, rmult_r, tgt_r, chg_r};
            peak_r <= '0;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/lbdg_chk.sv
// ----------------------------------------------------------------------------
// Load-based DVFS governor port checker
// Concurrent assertions on the core's ports, bound into the governor core.
// ----------------------------------------------------------------------------
module lbdg_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [71:0]  out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("Result dropped before its transfer.");

  a_no_change_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[22:1] == 22'd0)
    else $error("Target is nonzero without a change request.");

  a_mult_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:23] != 17'd0 && out_tdata[39:23] <= 17'd100000)
    else $error("Rate multiplier out of range.");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("Input taken while a sample is still in work.");

endmodule

bind load_based_dvfs_governor_core lbdg_chk u_lbdg_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
